### design/rpaf_pkg.sv
// rpaf_pkg: shared types and constants of the rotate-about-focus block
// holds the transfer structs, the pipeline state struct and the cordic angle table
// no dependencies
package rpaf_pkg;

   // coordinate format (signed q16.16), fixed by the transfer structs
   localparam int COORD_WIDTH = 32;
   localparam int ANGLE_WIDTH = 16;
   // extra fraction bits carried through the cordic stages
   localparam int GUARD_BITS  = 12;
   // pre-rotated difference (coord+1), guard bits, cordic growth and headroom
   localparam int DATA_WIDTH  = COORD_WIDTH + GUARD_BITS + 4;
   // angle accumulator in units of 2^-32 turn
   localparam int Z_WIDTH     = 32;
   // gain multiply works on a 64-bit magnitude in two 32-bit halves
   localparam int HALF_WIDTH  = 32;
   localparam int MAG_WIDTH   = 2 * HALF_WIDTH;

   localparam int CORDIC_STEPS_DEF = 16;
   localparam int ATAN_ENTRIES     = 24;

   // inverse of the converged cordic gain, 0.60725293 in 0.32 format
   localparam logic [HALF_WIDTH-1:0] GAIN_K = 32'h9B74EDA8;

   // atan(2^-i) in units of 2^-32 turn
   localparam logic [Z_WIDTH-1:0] ATAN_TABLE [0:ATAN_ENTRIES-1] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   // coarse pre-rotation selected by the top two bits of the shifted angle
   typedef enum logic [1:0] {
      QUAD_0   = 2'd0,
      QUAD_90  = 2'd1,
      QUAD_180 = 2'd2,
      QUAD_270 = 2'd3
   } quad_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] point_x;
      logic signed [COORD_WIDTH-1:0] point_y;
      logic signed [COORD_WIDTH-1:0] focus_x;
      logic signed [COORD_WIDTH-1:0] focus_y;
      logic        [ANGLE_WIDTH-1:0] angle_turn;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] rotated_x;
      logic signed [COORD_WIDTH-1:0] rotated_y;
   } rsp_type;

   // what travels down the cordic pipeline
   typedef struct packed {
      logic signed [DATA_WIDTH-1:0]  x;
      logic signed [DATA_WIDTH-1:0]  y;
      logic signed [Z_WIDTH-1:0]     z;
      logic signed [COORD_WIDTH-1:0] focus_x;
      logic signed [COORD_WIDTH-1:0] focus_y;
   } cordic_type;

endpackage

### design/rpaf_cordic_stage.sv
// rpaf_cordic_stage: one registered micro-rotation of the cordic pipeline
// depends on rpaf_pkg (cordic_type, ATAN_TABLE)
module rpaf_cordic_stage
   import rpaf_pkg::*;
#(
   parameter int STEP = 0
) (
   input  logic       clock,
   input  logic       en,
   input  cordic_type cur_stage,
   output cordic_type nxt_stage
);

   localparam logic signed [Z_WIDTH-1:0] ATAN_C = signed'(ATAN_TABLE[STEP]);

   cordic_type stage_ff;
   cordic_type stage_in;
   logic signed [DATA_WIDTH-1:0] x_shift;
   logic signed [DATA_WIDTH-1:0] y_shift;

   always_comb begin
      x_shift  = cur_stage.x >>> STEP;
      y_shift  = cur_stage.y >>> STEP;
      stage_in = cur_stage;
      // rotate towards zero residual angle
      if (!cur_stage.z[Z_WIDTH-1]) begin
         stage_in.x = cur_stage.x - y_shift;
         stage_in.y = cur_stage.y + x_shift;
         stage_in.z = cur_stage.z - ATAN_C;
      end else begin
         stage_in.x = cur_stage.x + y_shift;
         stage_in.y = cur_stage.y - x_shift;
         stage_in.z = cur_stage.z + ATAN_C;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         stage_ff <= stage_in;
      end
   end

   assign nxt_stage = stage_ff;

endmodule

### design/rpaf_gain.sv
// rpaf_gain: gain compensation, rounding, focus add and saturation for one coordinate
// four register stages; depends on rpaf_pkg (widths, GAIN_K)
module rpaf_gain
   import rpaf_pkg::*;
(
   input  logic                          clock,
   input  logic                          en,
   input  logic signed [DATA_WIDTH-1:0]  value_i,
   input  logic signed [COORD_WIDTH-1:0] focus_i,
   output logic signed [COORD_WIDTH-1:0] result_o
);

   localparam int REL_WIDTH = DATA_WIDTH - GUARD_BITS;
   localparam int SUM_WIDTH = REL_WIDTH + 1;
   localparam logic signed [DATA_WIDTH-1:0] ROUND_C = DATA_WIDTH'(1) << (GUARD_BITS - 1);
   localparam logic signed [COORD_WIDTH-1:0] MAX_C = {1'b0, {(COORD_WIDTH-1){1'b1}}};
   localparam logic signed [COORD_WIDTH-1:0] MIN_C = {1'b1, {(COORD_WIDTH-1){1'b0}}};

   // stage 1: sign and magnitude
   logic                          neg1_ff;
   logic [MAG_WIDTH-1:0]          mag1_ff;
   logic signed [COORD_WIDTH-1:0] foc1_ff;
   logic [DATA_WIDTH-1:0]         abs_val;
   logic [MAG_WIDTH-1:0]          mag1_in;

   // stage 2: partial products
   logic                          neg2_ff;
   logic [MAG_WIDTH-1:0]          plo2_ff;
   logic [MAG_WIDTH-1:0]          phi2_ff;
   logic signed [COORD_WIDTH-1:0] foc2_ff;
   logic [MAG_WIDTH-1:0]          plo2_in;
   logic [MAG_WIDTH-1:0]          phi2_in;

   // stage 3: scaled value with sign restored
   logic signed [DATA_WIDTH-1:0]  g3_ff;
   logic signed [COORD_WIDTH-1:0] foc3_ff;
   logic [MAG_WIDTH-1:0]          prod;
   logic signed [DATA_WIDTH-1:0]  g3_in;

   // stage 4: rounded, shifted, focus added, saturated
   logic signed [COORD_WIDTH-1:0] res4_ff;
   logic signed [COORD_WIDTH-1:0] res4_in;
   logic signed [DATA_WIDTH-1:0]  rounded;
   logic signed [REL_WIDTH-1:0]   rel;
   logic signed [SUM_WIDTH-1:0]   sum;

   always_comb begin
      abs_val = value_i[DATA_WIDTH-1] ? DATA_WIDTH'(-value_i) : DATA_WIDTH'(value_i);
      mag1_in = {{(MAG_WIDTH-DATA_WIDTH){1'b0}}, abs_val};

      plo2_in = MAG_WIDTH'(mag1_ff[HALF_WIDTH-1:0]) * MAG_WIDTH'(GAIN_K);
      phi2_in = MAG_WIDTH'(mag1_ff[MAG_WIDTH-1:HALF_WIDTH]) * MAG_WIDTH'(GAIN_K);

      // truncation toward zero: floor of the magnitude, then sign
      prod  = phi2_ff + {{HALF_WIDTH{1'b0}}, plo2_ff[MAG_WIDTH-1:HALF_WIDTH]};
      g3_in = neg2_ff ? -signed'(prod[DATA_WIDTH-1:0]) : signed'(prod[DATA_WIDTH-1:0]);

      // round half up, drop the guard bits
      rounded = g3_ff + ROUND_C;
      rel     = rounded[DATA_WIDTH-1:GUARD_BITS];
      sum     = SUM_WIDTH'(rel) + SUM_WIDTH'(foc3_ff);
      if (sum > SUM_WIDTH'(MAX_C)) begin
         res4_in = MAX_C;
      end else if (sum < SUM_WIDTH'(MIN_C)) begin
         res4_in = MIN_C;
      end else begin
         res4_in = sum[COORD_WIDTH-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         neg1_ff <= value_i[DATA_WIDTH-1];
         mag1_ff <= mag1_in;
         foc1_ff <= focus_i;
         neg2_ff <= neg1_ff;
         plo2_ff <= plo2_in;
         phi2_ff <= phi2_in;
         foc2_ff <= foc1_ff;
         g3_ff   <= g3_in;
         foc3_ff <= foc2_ff;
         res4_ff <= res4_in;
      end
   end

   assign result_o = res4_ff;

endmodule

### design/rotate_point_about_focus_top.sv
// rotate_point_about_focus_top: rotates a q16.16 point about a focus by a binary angle
// depends on rpaf_pkg, rpaf_cordic_stage and rpaf_gain
//
// usage
//  - req channel: one transfer carries point, focus and angle (65536 = one turn,
//    counterclockwise); rsp channel: one transfer carries the rotated point
//  - each request gives exactly one response, in order; nothing is kept between items
//  - pipeline: one input stage, one stage per cordic step, four gain and rounding
//    stages and the output register lie between the request transfer and rsp_valid;
//    steps above 24 are limited to 24
//  - throughput: one transfer per cycle while req_stall is low; cordic fully unrolled
//  - a stalled response sits in the output register; the next finished result
//    drops into a one-entry skid register, and only while that is full does
//    req_stall rise and the pipeline freeze, so nothing is lost or repeated
//  - req_stall is a register, with no path from rsp_stall
//  - reset clears every valid bit, including those of the output and the skid
//    register; their data is not reset, and in-flight items are dropped
//  - results saturate to the signed coordinate range
module rotate_point_about_focus_top
   import rpaf_pkg::*;
#(
   parameter int CORDIC_STEPS = CORDIC_STEPS_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   // steps limited to the angle table
   localparam int NSTEP    = (CORDIC_STEPS < ATAN_ENTRIES) ? CORDIC_STEPS : ATAN_ENTRIES;
   // input stage, cordic stages, gain stages
   localparam int PIPE_LEN = NSTEP + 5;
   localparam int DIFF_WIDTH = COORD_WIDTH + 1;
   localparam int EXT_WIDTH  = DATA_WIDTH - DIFF_WIDTH - GUARD_BITS;

   // pipeline advance: everything moves unless the skid register is holding a result
   logic en;
   logic accept;

   // one valid bit per pipeline stage
   logic [PIPE_LEN-1:0] valid_ff;
   logic [PIPE_LEN-1:0] valid_in;

   // input stage: difference, quadrant pre-rotation, residual angle
   cordic_type s0_ff;
   cordic_type s0_in;
   logic signed [DIFF_WIDTH-1:0] dx;
   logic signed [DIFF_WIDTH-1:0] dy;
   logic signed [DIFF_WIDTH-1:0] rx;
   logic signed [DIFF_WIDTH-1:0] ry;
   logic [ANGLE_WIDTH-1:0] angle_sh;
   quad_type quad;

   cordic_type stg [0:NSTEP];

   logic signed [COORD_WIDTH-1:0] gx;
   logic signed [COORD_WIDTH-1:0] gy;
   rsp_type res;

   // output register and skid register
   logic    out_valid_ff;
   logic    out_valid_in;
   rsp_type out_data_ff;
   rsp_type out_data_in;
   logic    skid_valid_ff;
   logic    skid_valid_in;
   rsp_type skid_data_ff;
   rsp_type skid_data_in;

   assign en        = !skid_valid_ff;
   assign req_stall = skid_valid_ff;
   assign accept    = req_valid && en;

   always_comb begin
      dx = DIFF_WIDTH'(req_data.point_x) - DIFF_WIDTH'(req_data.focus_x);
      dy = DIFF_WIDTH'(req_data.point_y) - DIFF_WIDTH'(req_data.focus_y);

      // shift by an eighth turn so the residual lands in +-45 degrees
      angle_sh = req_data.angle_turn + ANGLE_WIDTH'(16'h2000);
      quad     = quad_type'(angle_sh[ANGLE_WIDTH-1:ANGLE_WIDTH-2]);

      unique case (quad)
         QUAD_0: begin
            rx = dx;
            ry = dy;
         end
         QUAD_90: begin
            rx = -dy;
            ry = dx;
         end
         QUAD_180: begin
            rx = -dx;
            ry = -dy;
         end
         QUAD_270: begin
            rx = dy;
            ry = -dx;
         end
         default: begin
            rx = dx;
            ry = dy;
         end
      endcase

      // residual minus an eighth turn: flip the top bit, then scale to 2^-32 turn
      s0_in.x = {{EXT_WIDTH{rx[DIFF_WIDTH-1]}}, rx, {GUARD_BITS{1'b0}}};
      s0_in.y = {{EXT_WIDTH{ry[DIFF_WIDTH-1]}}, ry, {GUARD_BITS{1'b0}}};
      s0_in.z = {{2{~angle_sh[13]}}, ~angle_sh[13], angle_sh[12:0], 16'h0000};
      s0_in.focus_x = req_data.focus_x;
      s0_in.focus_y = req_data.focus_y;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         s0_ff <= s0_in;
      end
   end

   assign stg[0] = s0_ff;

   // unrolled micro-rotations, one register stage each
   for (genvar k = 0; k < NSTEP; k++) begin : g_step
      rpaf_cordic_stage #(
         .STEP(k)
      ) u_step (
         .clock     (clock),
         .en        (en),
         .cur_stage (stg[k]),
         .nxt_stage (stg[k+1])
      );
   end

   rpaf_gain u_gain_x (
      .clock    (clock),
      .en       (en),
      .value_i  (stg[NSTEP].x),
      .focus_i  (stg[NSTEP].focus_x),
      .result_o (gx)
   );

   rpaf_gain u_gain_y (
      .clock    (clock),
      .en       (en),
      .value_i  (stg[NSTEP].y),
      .focus_i  (stg[NSTEP].focus_y),
      .result_o (gy)
   );

   assign res.rotated_x = gx;
   assign res.rotated_y = gy;

   // valid bits ride along with the data
   assign valid_in = {valid_ff[PIPE_LEN-2:0], accept};

   always_comb begin
      out_valid_in  = out_valid_ff;
      out_data_in   = out_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (en) begin
         if (out_valid_ff && rsp_stall) begin
            // output held: park the arriving result in the skid register
            if (valid_ff[PIPE_LEN-1]) begin
               skid_valid_in = 1'b1;
               skid_data_in  = res;
            end
         end else begin
            out_valid_in = valid_ff[PIPE_LEN-1];
            out_data_in  = res;
         end
      end else begin
         // pipeline frozen: drain the skid register once the output is taken
         if (!rsp_stall) begin
            out_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         if (en) begin
            valid_ff <= valid_in;
         end
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_data_ff  <= out_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_data_ff;

   // the skid register only holds a result behind a full output register
   a_skid_behind_out : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid register full while output register empty");

   // the skid register fills only when the output was held
   a_skid_fill : assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(out_valid_ff && rsp_stall))
      else $error("skid register filled without a stalled output");

   // a full skid register freezes the pipeline
   a_freeze : assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |=> $stable(valid_ff))
      else $error("pipeline moved while skid register full");

   // taking the output while the skid is full hands the parked result over
   a_skid_drain : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_stall && skid_valid_ff) |=> (rsp_valid && !skid_valid_ff))
      else $error("parked result lost on drain");

endmodule
